// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define PPAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define PPAC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/ppac_pkg.sv
// Package: constants and arctangent table for the polar conversion block.
`default_nettype none
package ppac_pkg;

    localparam int C_COORD_BITS     = 16;
    localparam int C_ANGLE_BITS     = 16;
    localparam int C_ROTATION_STEPS = 16;
    localparam int C_QUEUE_DEPTH    = 4;

    localparam int GUARD_BITS   = 20;
    localparam int ATAN_ENTRIES = 24;
    localparam int MAG_BITS     = 17;

    // inverse CORDIC gain, Q32
    localparam logic [31:0] C_INV_GAIN_Q32 = 32'd2608131496;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] C_ATAN_TURN_Q32 [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [31:0] C_HALF_TURN = 32'h80000000;

endpackage
`default_nettype wire

// File: rtl/ppac_front.sv
// Front end: takes coordinate words, forms the difference vector and flags coincidence.
`default_nettype none
module ppac_front #(
    parameter int COORD_BITS = ppac_pkg::C_COORD_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [COORD_BITS-1:0]   i_center_x,
    input  wire logic [COORD_BITS-1:0]   i_center_y,
    input  wire logic [COORD_BITS-1:0]   i_point_x,
    input  wire logic [COORD_BITS-1:0]   i_point_y,
    output logic                         o_item_valid,
    input  wire logic                    i_item_ready,
    output logic [2*COORD_BITS+2:0]      o_item
);
    import ppac_pkg::*;

    localparam int CW = COORD_BITS + 1;

    logic                 r_valid;
    logic signed [CW-1:0] r_dx;
    logic signed [CW-1:0] r_dy;
    logic                 r_coinc;
    logic signed [CW-1:0] n_dx;
    logic signed [CW-1:0] n_dy;
    logic                 w_accept;

    assign o_in_ready = !r_valid || i_item_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_dx = CW'(signed'(i_point_x)) - CW'(signed'(i_center_x));
        n_dy = CW'(signed'(i_point_y)) - CW'(signed'(i_center_y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_coinc <= (n_dx == '0) && (n_dy == '0);
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = {r_coinc, r_dy, r_dx};

endmodule
`default_nettype wire

// File: rtl/ppac_queue.sv
// Short queue between front end and CORDIC pipeline.
`default_nettype none
module ppac_queue #(
    parameter int DATA_BITS = 35,
    parameter int DEPTH     = ppac_pkg::C_QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push_valid,
    output logic                      o_push_ready,
    input  wire logic [DATA_BITS-1:0] i_push_data,
    output logic                      o_pop_valid,
    input  wire logic                 i_pop_ready,
    output logic [DATA_BITS-1:0]      o_pop_data
);
    import ppac_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_BITS-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]        r_wr;
    logic [AW-1:0]        r_rd;
    logic [AW:0]          r_count;
    logic                 w_push;
    logic                 w_pop;
    logic [AW-1:0]        n_wr;
    logic [AW-1:0]        n_rd;

    assign o_push_ready = (r_count != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    always_comb begin
        n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ppac_back.sv
// Back end: unrolled vectoring CORDIC, gain correction and output register.
`default_nettype none
module ppac_back #(
    parameter int COORD_BITS     = ppac_pkg::C_COORD_BITS,
    parameter int ANGLE_BITS     = ppac_pkg::C_ANGLE_BITS,
    parameter int ROTATION_STEPS = ppac_pkg::C_ROTATION_STEPS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_item_valid,
    output logic                                o_item_ready,
    input  wire logic [2*COORD_BITS+2:0]        i_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [ANGLE_BITS-1:0]               o_turn_angle,
    output logic [ppac_pkg::MAG_BITS-1:0]       o_magnitude,
    output logic                                o_coincident
);
    import ppac_pkg::*;

    localparam int CW      = COORD_BITS + 1;
    localparam int XW      = CW + GUARD_BITS + 2;
    localparam int STEPS   = (ROTATION_STEPS < ATAN_ENTRIES) ? ROTATION_STEPS : ATAN_ENTRIES;
    localparam int UX_BITS = (XW - 1 > 33) ? XW - 1 : 33;
    localparam int T_BITS  = (UX_BITS + 1 > GUARD_BITS + MAG_BITS + 1) ?
                             UX_BITS + 1 : GUARD_BITS + MAG_BITS + 1;
    localparam logic [T_BITS-1:0] C_ROUND = T_BITS'(1) << (GUARD_BITS - 1);
    localparam logic [31:0] C_ANG_ROUND = 32'd1 << (31 - ANGLE_BITS);

    logic                 w_en;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic                 w_coinc;

    // CORDIC stages
    logic [STEPS:0]       r_v;
    logic signed [XW-1:0] r_x   [0:STEPS];
    logic signed [XW-1:0] r_y   [0:STEPS];
    logic [31:0]          r_acc [0:STEPS];
    logic                 r_c   [0:STEPS];
    logic signed [XW-1:0] n_x   [0:STEPS-1];
    logic signed [XW-1:0] n_y   [0:STEPS-1];
    logic [31:0]          n_acc [0:STEPS-1];
    logic signed [XW-1:0] n_x0;
    logic signed [XW-1:0] n_y0;

    // gain correction and output
    logic [UX_BITS-1:0]   w_ux;
    logic [63:0]          n_lo;
    logic [UX_BITS-1:0]   n_hi;
    logic                 r_m1_v;
    logic [31:0]          r_m1_lo;
    logic [UX_BITS-1:0]   r_m1_hi;
    logic [31:0]          r_m1_acc;
    logic                 r_m1_c;
    logic                 r_m2_v;
    logic [T_BITS-1:0]    r_m2_t;
    logic [31:0]          r_m2_acc;
    logic                 r_m2_c;
    logic                 r_out_v;
    logic [ANGLE_BITS-1:0] r_ang;
    logic [MAG_BITS-1:0]  r_mag;
    logic                 r_coinc;
    logic [31:0]          n_ang_sum;
    logic [MAG_BITS-1:0]  n_mag;

    assign w_en         = !r_out_v || i_out_ready;
    assign o_item_ready = w_en;
    assign w_dx         = signed'(i_item[CW-1:0]);
    assign w_dy         = signed'(i_item[2*CW-1:CW]);
    assign w_coinc      = i_item[2*CW];

    always_comb begin
        n_x0 = XW'(w_dx) <<< GUARD_BITS;
        n_y0 = XW'(w_dy) <<< GUARD_BITS;
    end

    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            if (!r_y[k][XW-1]) begin
                n_x[k]   = r_x[k] + (r_y[k] >>> k);
                n_y[k]   = r_y[k] - (r_x[k] >>> k);
                n_acc[k] = r_acc[k] + C_ATAN_TURN_Q32[k];
            end else begin
                n_x[k]   = r_x[k] - (r_y[k] >>> k);
                n_y[k]   = r_y[k] + (r_x[k] >>> k);
                n_acc[k] = r_acc[k] - C_ATAN_TURN_Q32[k];
            end
        end
    end

    always_comb begin
        w_ux      = UX_BITS'(r_x[STEPS][XW-2:0]);
        n_lo      = 64'(w_ux[31:0]) * 64'(C_INV_GAIN_Q32);
        n_hi      = UX_BITS'(w_ux[UX_BITS-1:32]) * UX_BITS'(C_INV_GAIN_Q32);
        n_ang_sum = r_m2_acc + C_ANG_ROUND;
        if (r_m2_t[T_BITS-1:GUARD_BITS+MAG_BITS] != '0) begin
            n_mag = '1;
        end else begin
            n_mag = r_m2_t[GUARD_BITS+MAG_BITS-1:GUARD_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v     <= {r_v[STEPS-1:0], i_item_valid};
            r_m1_v  <= r_v[STEPS];
            r_m2_v  <= r_m1_v;
            r_out_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_dx[CW-1]) begin
                r_x[0]   <= -n_x0;
                r_y[0]   <= -n_y0;
                r_acc[0] <= C_HALF_TURN;
            end else begin
                r_x[0]   <= n_x0;
                r_y[0]   <= n_y0;
                r_acc[0] <= '0;
            end
            r_c[0] <= w_coinc;
            for (int k = 0; k < STEPS; k++) begin
                r_x[k+1]   <= n_x[k];
                r_y[k+1]   <= n_y[k];
                r_acc[k+1] <= n_acc[k];
                r_c[k+1]   <= r_c[k];
            end
            r_m1_lo  <= n_lo[63:32];
            r_m1_hi  <= n_hi;
            r_m1_acc <= r_acc[STEPS];
            r_m1_c   <= r_c[STEPS];
            r_m2_t   <= T_BITS'(r_m1_hi) + T_BITS'(r_m1_lo) + C_ROUND;
            r_m2_acc <= r_m1_acc;
            r_m2_c   <= r_m1_c;
            r_ang    <= r_m2_c ? '0 : n_ang_sum[31 -: ANGLE_BITS];
            r_mag    <= r_m2_c ? '0 : n_mag;
            r_coinc  <= r_m2_c;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_turn_angle = r_ang;
    assign o_magnitude  = r_mag;
    assign o_coincident = r_coinc;

endmodule
`default_nettype wire

// File: rtl/point_to_polar_about_center.sv
// Top level: polar form of a point about a centre.
// One word in and one word out per cycle when neither side stalls. The
// front-end register is loaded at the accepting edge; the word then passes
// through the queue, one half-turn pre-rotation stage, one stage per CORDIC
// rotation (at most 24), two stages of gain correction and the output
// register. A waiting result freezes the whole pipeline; the four-word queue
// and the front-end register still take up to five words before input stalls.
// The angle is 2^ANGLE_BITS units per turn, counter-clockwise from +x; the
// magnitude is the rounded distance, saturating at 131071. Coincident points
// give angle 0, magnitude 0 and the coincident flag.
`default_nettype none
module point_to_polar_about_center #(
    parameter int COORD_BITS     = ppac_pkg::C_COORD_BITS,
    parameter int ANGLE_BITS     = ppac_pkg::C_ANGLE_BITS,
    parameter int ROTATION_STEPS = ppac_pkg::C_ROTATION_STEPS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [COORD_BITS-1:0]     i_center_x,
    input  wire logic [COORD_BITS-1:0]     i_center_y,
    input  wire logic [COORD_BITS-1:0]     i_point_x,
    input  wire logic [COORD_BITS-1:0]     i_point_y,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [ANGLE_BITS-1:0]          o_turn_angle,
    output logic [ppac_pkg::MAG_BITS-1:0]  o_magnitude,
    output logic                           o_coincident
);
    import ppac_pkg::*;

    localparam int ITEM_BITS = 2 * COORD_BITS + 3;

    logic                 w_f_valid;
    logic                 w_f_ready;
    logic [ITEM_BITS-1:0] w_f_item;
    logic                 w_q_valid;
    logic                 w_q_ready;
    logic [ITEM_BITS-1:0] w_q_item;

    ppac_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .o_item_valid (w_f_valid),
        .i_item_ready (w_f_ready),
        .o_item       (w_f_item)
    );

    ppac_queue #(
        .DATA_BITS (ITEM_BITS),
        .DEPTH     (C_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_data  (w_f_item),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_item)
    );

    ppac_back #(
        .COORD_BITS     (COORD_BITS),
        .ANGLE_BITS     (ANGLE_BITS),
        .ROTATION_STEPS (ROTATION_STEPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_item       (w_q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_turn_angle (o_turn_angle),
        .o_magnitude  (o_magnitude),
        .o_coincident (o_coincident)
    );

endmodule
`default_nettype wire

// File: rtl/ppac_checker.sv
// Checker on the top-level output port, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ppac_checker #(
    parameter int ANGLE_BITS = ppac_pkg::C_ANGLE_BITS
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [ANGLE_BITS-1:0]         o_turn_angle,
    input wire logic [ppac_pkg::MAG_BITS-1:0] o_magnitude,
    input wire logic                          o_coincident
);
    import ppac_pkg::*;

    `PPAC_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_turn_angle)
            && $stable(o_magnitude) && $stable(o_coincident),
        "output word changed while stalled")
    `PPAC_ASSERT(a_coinc_zero, i_clk, i_rst_n,
        o_out_valid && o_coincident |-> (o_turn_angle == '0) && (o_magnitude == '0),
        "coincident word with nonzero angle or magnitude")
    `PPAC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid,
        "output valid just after reset")

endmodule

bind point_to_polar_about_center ppac_checker #(
    .ANGLE_BITS (ANGLE_BITS)
) u_ppac_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_turn_angle (o_turn_angle),
    .o_magnitude  (o_magnitude),
    .o_coincident (o_coincident)
);
`default_nettype wire
